// ===== rtl/rlpd_pkg.sv =====
// Shared types and constants of the RLP stream decoder.
`timescale 1ns / 1ps

package rlpd_pkg;

  // Width of a byte position and of a list end position
  localparam int unsigned POS_W = 17;

  // Header byte boundaries
  localparam logic [7:0] STR_SHORT  = 8'h80;
  localparam logic [7:0] STR_LONG   = 8'hb8;
  localparam logic [7:0] LIST_SHORT = 8'hc0;
  localparam logic [7:0] LIST_LONG  = 8'hf8;
  localparam logic [7:0] STR_LBASE  = 8'hb7;
  localparam logic [7:0] LIST_LBASE = 8'hf7;

  // Longest supported length-of-length field
  localparam logic [7:0] MAX_LLEN = 8'd2;

  // Parse phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LEN     = 2'd1,
    ERR_OVERRUN = 2'd2,
    ERR_LIMIT   = 2'd3
  } err_e;

  // Control broadcast to every stack cell
  typedef struct packed {
    logic             step;      // a byte is taken this cycle
    logic             clear;     // message start: treat the stack as empty
    logic             pop_en;    // header byte: close lists ending here
    logic [POS_W-1:0] pos;       // position of the current byte
    logic             push;      // open a new list
    logic [POS_W-1:0] push_end;  // end position of the new list
  } cell_ctrl_t;

endpackage

// ===== rtl/rlpd_cell.sv =====
// One entry of the list-end stack, chained with its neighbours.
`timescale 1ns / 1ps

module rlpd_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rlpd_pkg::cell_ctrl_t       ctrl_i,
  input  logic                       below_surv_i,
  input  logic                       above_surv_i,
  input  logic [rlpd_pkg::POS_W-1:0] above_top_i,
  output logic                       surv_o,
  output logic [rlpd_pkg::POS_W-1:0] top_o
);

  logic                       valid_q, valid_d;
  logic [rlpd_pkg::POS_W-1:0] end_q, end_d;
  logic                       valid_e;
  logic                       wr;

  // Keep the entry unless it closes here and nothing above it stays open
  always_comb begin
    valid_e = valid_q && !ctrl_i.clear;
    surv_o  = valid_e && (!ctrl_i.pop_en || (end_q != ctrl_i.pos) || above_surv_i);
    wr      = ctrl_i.push && below_surv_i && !surv_o;
    valid_d = surv_o || wr;
    end_d   = wr ? ctrl_i.push_end : end_q;
    top_o   = above_surv_i ? above_top_i : end_q;
  end

  // Hold the open flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.step) begin
      valid_q <= valid_d;
    end
  end

  // Hold the end position
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      end_q <= end_d;
    end
  end

endmodule

// ===== rtl/rlp_stream_decoder_top.sv =====
// Top level of the RLP stream decoder: header parser, stack cell row and output register.
`timescale 1ns / 1ps

// Decodes an RLP message arriving one byte per transaction and gives every payload
// byte of every string item as one output transaction, tagged with its item number,
// the number of open enclosing lists and a last-byte mark (tlast); an empty string
// gives one transaction with tuser set. List headers give no output. The block takes
// one byte per cycle while the output register is empty or being read; the rate is set
// by the row of MAX_DEPTH stack cells, which close every list that ends at a header
// byte in the same cycle. An error (length over 16 bits, item overrunning its list,
// depth or item limit) gives one transaction with a nonzero error code, after which
// bytes are consumed silently until a byte with s_axis_tuser set starts a new message.
module rlp_stream_decoder_top #(
  parameter int unsigned MAX_DEPTH = 8,
  parameter int unsigned MAX_ITEMS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] msg_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [14:8] item_index,
                                      // [18:15] nest_depth, [20:19] error_code
  output logic        m_axis_tlast,   // item_last
  output logic        m_axis_tuser    // [0] item_empty
);

  localparam int unsigned ICW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned PW  = rlpd_pkg::POS_W;

  // Parser state
  rlpd_pkg::phase_e phase_q, phase_d, phase_e;
  logic [1:0]       lbl_q, lbl_d;
  logic             is_list_q, is_list_d;
  logic [15:0]      accum_q, accum_d;
  logic [15:0]      pl_q, pl_d;
  logic [PW-1:0]    pos_q, pos_d, pos_e, pos_h;
  logic [ICW-1:0]   count_q, count_d, count_e;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic [6:0]  out_index_q;
  logic        out_last_q;
  logic        out_empty_q;
  logic [3:0]  out_depth_q;
  logic [1:0]  out_err_q;

  // Stack cell row
  rlpd_pkg::cell_ctrl_t ctrl;
  logic [MAX_DEPTH+1:0] surv;
  logic [PW-1:0]        tops [MAX_DEPTH+1];
  logic [DW-1:0]        depth;
  logic [PW-1:0]        top_end;

  // Decode signals
  logic             accept;
  logic [7:0]       b;
  logic             b_is_list, b_is_long;
  logic [7:0]       len_op;
  logic [15:0]      new_accum;
  logic [15:0]      hd_len;
  logic [PW:0]      end_sum;
  logic             ov;
  logic             hd, hd_list;
  logic             push;
  logic             emit;
  logic [7:0]       e_data;
  logic             e_last, e_empty;
  rlpd_pkg::err_e   e_err;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign b             = s_axis_tdata;

  // Apply message start to the state seen by this byte
  always_comb begin
    phase_e = s_axis_tuser ? rlpd_pkg::PH_HEADER : phase_q;
    pos_e   = s_axis_tuser ? '0 : pos_q;
    count_e = s_axis_tuser ? '0 : count_q;
  end

  // Drive the cell row
  always_comb begin
    ctrl.step     = accept;
    ctrl.clear    = s_axis_tuser;
    ctrl.pop_en   = (phase_e == rlpd_pkg::PH_HEADER);
    ctrl.pos      = pos_e;
    ctrl.push     = push;
    ctrl.push_end = end_sum[PW-1:0];
  end

  assign surv[0]           = 1'b1;
  assign surv[MAX_DEPTH+1] = 1'b0;
  assign tops[MAX_DEPTH]   = '0;
  assign top_end           = tops[0];

  for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
    rlpd_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .below_surv_i (surv[k]),
      .above_surv_i (surv[k+2]),
      .above_top_i  (tops[k+1]),
      .surv_o       (surv[k+1]),
      .top_o        (tops[k])
    );
  end

  // Count open lists after closing those that end here
  always_comb begin
    depth = '0;
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (surv[k+1]) begin
        depth = DW'(k + 1);
      end
    end
  end

  // Restart the position at each top-level header
  assign pos_h = ((phase_e == rlpd_pkg::PH_HEADER) && (depth == '0)) ? '0 : pos_e;

  // Classify the header byte and pick the length that ends the header or item
  always_comb begin
    b_is_list = (b >= rlpd_pkg::LIST_SHORT);
    b_is_long = ((b >= rlpd_pkg::STR_LONG) && (b < rlpd_pkg::LIST_SHORT)) ||
                (b >= rlpd_pkg::LIST_LONG);
    if (b < rlpd_pkg::STR_SHORT) begin
      len_op = 8'd0;
    end else if (b < rlpd_pkg::STR_LONG) begin
      len_op = b - rlpd_pkg::STR_SHORT;
    end else if (b < rlpd_pkg::LIST_SHORT) begin
      len_op = b - rlpd_pkg::STR_LBASE;
    end else if (b < rlpd_pkg::LIST_LONG) begin
      len_op = b - rlpd_pkg::LIST_SHORT;
    end else begin
      len_op = b - rlpd_pkg::LIST_LBASE;
    end
    new_accum = {accum_q[7:0], b};
    hd_len    = (phase_e == rlpd_pkg::PH_HEADER) ? {8'd0, len_op} : new_accum;
    end_sum   = {1'b0, pos_h} + (PW+1)'(1) + (PW+1)'(hd_len);
    ov        = (depth != '0) && (end_sum > {1'b0, top_end});
  end

  // Parse one byte
  always_comb begin
    phase_d   = phase_e;
    lbl_d     = lbl_q;
    accum_d   = accum_q;
    pl_d      = pl_q;
    is_list_d = is_list_q;
    count_d   = count_e;
    emit      = 1'b0;
    e_data    = 8'd0;
    e_last    = 1'b0;
    e_empty   = 1'b0;
    e_err     = rlpd_pkg::ERR_NONE;
    push      = 1'b0;
    hd        = 1'b0;
    hd_list   = is_list_q;

    case (phase_e)
      rlpd_pkg::PH_HEADER: begin
        is_list_d = b_is_list;
        hd_list   = b_is_list;
        if (b_is_list && (depth >= DW'(MAX_DEPTH))) begin
          phase_d = rlpd_pkg::PH_ERROR;
          emit    = 1'b1;
          e_err   = (b_is_long && (len_op > rlpd_pkg::MAX_LLEN)) ?
                    rlpd_pkg::ERR_LEN : rlpd_pkg::ERR_LIMIT;
        end else if (!b_is_list && (count_e >= ICW'(MAX_ITEMS))) begin
          phase_d = rlpd_pkg::PH_ERROR;
          emit    = 1'b1;
          if (b_is_long && (len_op > rlpd_pkg::MAX_LLEN)) begin
            e_err = rlpd_pkg::ERR_LEN;
          end else if (ov) begin
            e_err = rlpd_pkg::ERR_OVERRUN;
          end else begin
            e_err = rlpd_pkg::ERR_LIMIT;
          end
        end else if (b < rlpd_pkg::STR_SHORT) begin
          emit    = 1'b1;
          e_data  = b;
          e_last  = 1'b1;
          count_d = count_e + ICW'(1);
        end else if (!b_is_long) begin
          accum_d = {8'd0, len_op};
          hd      = 1'b1;
        end else if (len_op > rlpd_pkg::MAX_LLEN) begin
          phase_d = rlpd_pkg::PH_ERROR;
          emit    = 1'b1;
          e_err   = rlpd_pkg::ERR_LEN;
        end else if (ov) begin
          phase_d = rlpd_pkg::PH_ERROR;
          emit    = 1'b1;
          e_err   = rlpd_pkg::ERR_OVERRUN;
        end else begin
          accum_d = 16'd0;
          lbl_d   = len_op[1:0];
          phase_d = rlpd_pkg::PH_LENGTH;
        end
      end
      rlpd_pkg::PH_LENGTH: begin
        accum_d = new_accum;
        lbl_d   = lbl_q - 2'd1;
        if (lbl_q == 2'd1) begin
          hd = 1'b1;
        end
      end
      rlpd_pkg::PH_PAYLOAD: begin
        pl_d   = pl_q - 16'd1;
        emit   = 1'b1;
        e_data = b;
        e_last = (pl_q == 16'd1);
        if (pl_q == 16'd1) begin
          count_d = count_e + ICW'(1);
          phase_d = rlpd_pkg::PH_HEADER;
        end
      end
      rlpd_pkg::PH_ERROR: begin
        phase_d = rlpd_pkg::PH_ERROR;
      end
      default: begin
        phase_d = rlpd_pkg::PH_ERROR;
      end
    endcase

    // Finish a header: flag an overrun, or open a list, give an empty string or start the payload
    if (hd) begin
      if (ov) begin
        phase_d = rlpd_pkg::PH_ERROR;
        emit    = 1'b1;
        e_err   = rlpd_pkg::ERR_OVERRUN;
      end else if (hd_list) begin
        push    = 1'b1;
        phase_d = rlpd_pkg::PH_HEADER;
      end else if (hd_len == 16'd0) begin
        emit    = 1'b1;
        e_last  = 1'b1;
        e_empty = 1'b1;
        count_d = count_e + ICW'(1);
        phase_d = rlpd_pkg::PH_HEADER;
      end else begin
        pl_d    = hd_len;
        phase_d = rlpd_pkg::PH_PAYLOAD;
      end
    end

    pos_d = pos_h + PW'(1);
  end

  // Advance the parser state on each taken byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rlpd_pkg::PH_HEADER;
      lbl_q     <= 2'd0;
      is_list_q <= 1'b0;
      accum_q   <= 16'd0;
      pl_q      <= 16'd0;
      pos_q     <= '0;
      count_q   <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      lbl_q     <= lbl_d;
      is_list_q <= is_list_d;
      accum_q   <= accum_d;
      pl_q      <= pl_d;
      pos_q     <= pos_d;
      count_q   <= count_d;
    end
  end

  // Hold a result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_data_q  <= e_data;
      out_index_q <= 7'(count_e);
      out_last_q  <= e_last;
      out_empty_q <= e_empty;
      out_depth_q <= 4'(depth);
      out_err_q   <= e_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_err_q, out_depth_q, out_index_q, out_data_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_empty_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the RLP stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LIM_DEPTH  = 8;
  localparam int unsigned LIM_ITEMS  = 128;
  localparam int unsigned RAND_ITEMS = 250;

  // One decoded output transaction
  typedef struct packed {
    logic [7:0]       data;
    logic [6:0]       idx;
    logic [3:0]       depth;
    rlpd_pkg::err_e   err;
    logic             last;
    logic             empty;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] in_byte
  logic        s_axis_tuser = 1'b0;     // [0] msg_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;            // [7:0] payload_byte, [14:8] item_index,
                                        // [18:15] nest_depth, [20:19] error_code
  logic        m_axis_tlast;            // item_last
  logic        m_axis_tuser;            // [0] item_empty

  decoded_t    decoded_q[$];
  int unsigned n_fail = 0;
  int unsigned n_live = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;

  // Decoder state kept by the predictor
  rlpd_pkg::phase_e dec_phase;
  int unsigned      len_left;
  int unsigned      len_acc;
  int unsigned      pay_left;
  int unsigned      pos;
  int unsigned      n_items;
  int unsigned      open_lists;
  bit               hdr_list;
  int unsigned      list_ends[LIM_DEPTH];

  rlp_stream_decoder_top #(
    .MAX_DEPTH(LIM_DEPTH),
    .MAX_ITEMS(LIM_ITEMS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_decoder();
    dec_phase  = rlpd_pkg::PH_HEADER;
    len_left   = 0;
    len_acc    = 0;
    pay_left   = 0;
    pos        = 0;
    n_items    = 0;
    open_lists = 0;
    hdr_list   = 1'b0;
    foreach (list_ends[i]) list_ends[i] = 0;
  endfunction

  function automatic void put_result(logic [7:0] d, logic last, logic empty,
                                     rlpd_pkg::err_e e);
    decoded_t r;
    r.data  = d;
    r.idx   = 7'(n_items);
    r.depth = 4'(open_lists);
    r.err   = e;
    r.last  = last;
    r.empty = empty;
    decoded_q.push_back(r);
  endfunction

  function automatic void dec_fail(rlpd_pkg::err_e e);
    dec_phase = rlpd_pkg::PH_ERROR;
    put_result(8'h00, 1'b0, 1'b0, e);
  endfunction

  function automatic bit end_overruns(int unsigned end_pos);
    return open_lists > 0 && end_pos > list_ends[open_lists - 1];
  endfunction

  // Header and any length bytes are complete: len_acc holds the body length
  function automatic void dec_header_end();
    int unsigned end_pos;
    end_pos = pos + 1 + len_acc;
    if (end_overruns(end_pos)) begin
      dec_fail(rlpd_pkg::ERR_OVERRUN);
    end else if (hdr_list) begin
      list_ends[open_lists] = end_pos;
      open_lists++;
      dec_phase = rlpd_pkg::PH_HEADER;
    end else if (len_acc == 0) begin
      dec_phase = rlpd_pkg::PH_HEADER;
      put_result(8'h00, 1'b1, 1'b1, rlpd_pkg::ERR_NONE);
      n_items++;
    end else begin
      pay_left  = len_acc;
      dec_phase = rlpd_pkg::PH_PAYLOAD;
    end
  endfunction

  function automatic void dec_header(logic [7:0] b);
    int unsigned v;
    int unsigned llen;
    int unsigned body;
    v = b;
    // close every list ending at this byte
    while (open_lists > 0 && list_ends[open_lists - 1] == pos) open_lists--;
    if (open_lists == 0) pos = 0;
    hdr_list = (v >= rlpd_pkg::LIST_SHORT);

    // depth limit, with length-too-long taking priority
    if (hdr_list && open_lists >= LIM_DEPTH) begin
      if (v >= rlpd_pkg::LIST_LONG && v - rlpd_pkg::LIST_LBASE > rlpd_pkg::MAX_LLEN)
        dec_fail(rlpd_pkg::ERR_LEN);
      else dec_fail(rlpd_pkg::ERR_LIMIT);
      return;
    end
    // item limit, checked after length and overrun
    if (!hdr_list && n_items >= LIM_ITEMS) begin
      if (v >= rlpd_pkg::STR_LONG && v - rlpd_pkg::STR_LBASE > rlpd_pkg::MAX_LLEN) begin
        dec_fail(rlpd_pkg::ERR_LEN);
      end else begin
        body = (v >= rlpd_pkg::STR_LONG) ? v - rlpd_pkg::STR_LBASE :
               (v >= rlpd_pkg::STR_SHORT) ? v - rlpd_pkg::STR_SHORT : 0;
        if (end_overruns(pos + 1 + body)) dec_fail(rlpd_pkg::ERR_OVERRUN);
        else dec_fail(rlpd_pkg::ERR_LIMIT);
      end
      return;
    end

    if (v < rlpd_pkg::STR_SHORT) begin
      put_result(b, 1'b1, 1'b0, rlpd_pkg::ERR_NONE);
      n_items++;
      return;
    end
    if (v < rlpd_pkg::STR_LONG ||
        (v >= rlpd_pkg::LIST_SHORT && v < rlpd_pkg::LIST_LONG)) begin
      len_acc = v - (hdr_list ? rlpd_pkg::LIST_SHORT : rlpd_pkg::STR_SHORT);
      dec_header_end();
      return;
    end
    llen = v - (hdr_list ? rlpd_pkg::LIST_LBASE : rlpd_pkg::STR_LBASE);
    if (llen > rlpd_pkg::MAX_LLEN) begin
      dec_fail(rlpd_pkg::ERR_LEN);
    end else if (end_overruns(pos + 1 + llen)) begin
      dec_fail(rlpd_pkg::ERR_OVERRUN);
    end else begin
      len_acc   = 0;
      len_left  = llen;
      dec_phase = rlpd_pkg::PH_LENGTH;
    end
  endfunction

  // Advance the predictor by one byte; return 1 if the byte is not ignored
  function automatic bit decode_byte(logic [7:0] b, logic start);
    bit live;
    if (start) clear_decoder();
    live = (dec_phase != rlpd_pkg::PH_ERROR);
    case (dec_phase)
      rlpd_pkg::PH_HEADER: dec_header(b);
      rlpd_pkg::PH_LENGTH: begin
        len_acc  = ((len_acc << 8) | b) & 32'hffff;
        len_left = (len_left - 1) & 32'hf;
        if (len_left == 0) dec_header_end();
      end
      rlpd_pkg::PH_PAYLOAD: begin
        pay_left = (pay_left - 1) & 32'hffff;
        put_result(b, pay_left == 0, 1'b0, rlpd_pkg::ERR_NONE);
        if (pay_left == 0) begin
          n_items++;
          dec_phase = rlpd_pkg::PH_HEADER;
        end
      end
      default: ;
    endcase
    pos = (pos + 1) & 32'h1ffff;
    return live;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    n_fail++;
  endtask

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    decoded_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("transaction with none pending", m_axis_tdata, 0);
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata[7:0] !== want.data)
          report_mismatch("payload_byte", m_axis_tdata[7:0], want.data);
        if (m_axis_tdata[14:8] !== want.idx)
          report_mismatch("item_index", m_axis_tdata[14:8], want.idx);
        if (m_axis_tdata[18:15] !== want.depth)
          report_mismatch("nest_depth", m_axis_tdata[18:15], want.depth);
        if (m_axis_tdata[20:19] !== want.err)
          report_mismatch("error_code", m_axis_tdata[20:19], want.err);
        if (m_axis_tdata[23:21] !== 3'b000)
          report_mismatch("tdata padding", m_axis_tdata[23:21], 0);
        if (m_axis_tlast !== want.last)
          report_mismatch("item_last", m_axis_tlast, want.last);
        if (m_axis_tuser !== want.empty)
          report_mismatch("item_empty", m_axis_tuser, want.empty);
      end
    end
  end

  // Receiver: random stalls, quiet stretches and requested hold-offs
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(logic [7:0] b, logic start);
    int unsigned gap;
    gap = 0;
    // idle cycle by cycle, about one in five
    while (!tx_quiet && $urandom_range(0, 99) < 20) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (decode_byte(b, start)) n_live++;
  endtask

  // Send the first n bytes of a message, the first one flagged as message start
  task automatic send_msg(ref logic [7:0] msg[$], input int unsigned n);
    for (int unsigned i = 0; i < n && i < msg.size(); i++) send_byte(msg[i], i == 0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic void put_header(ref logic [7:0] q[$], input bit is_list,
                                     input int unsigned len);
    logic [7:0]  sbase;
    logic [7:0]  lbase;
    int unsigned llen;
    sbase = is_list ? rlpd_pkg::LIST_SHORT : rlpd_pkg::STR_SHORT;
    lbase = is_list ? rlpd_pkg::LIST_LBASE : rlpd_pkg::STR_LBASE;
    if (len <= 55 && $urandom_range(0, 3) != 0) begin
      q.push_back(8'(sbase + len));
    end else begin
      // long form, sometimes with a needless second length byte
      llen = (len > 255 || $urandom_range(0, 3) == 0) ? 2 : 1;
      q.push_back(8'(lbase + llen));
      if (llen == 2) q.push_back(8'(len >> 8));
      q.push_back(8'(len));
    end
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(1, 8);
    if (r < 98) return $urandom_range(9, 60);
    return $urandom_range(250, 300);
  endfunction

  // Append one well-formed item; lvl bounds the list nesting
  function automatic void gen_item(ref logic [7:0] q[$], input int unsigned lvl);
    logic [7:0]  sub[$];
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    if (lvl > 0 && kind < 30) begin
      repeat ($urandom_range(0, 4)) gen_item(sub, lvl - 1);
      put_header(q, 1'b1, sub.size());
      foreach (sub[i]) q.push_back(sub[i]);
    end else if (kind < 50) begin
      q.push_back(8'($urandom_range(0, 127)));
    end else begin
      len = pick_len();
      put_header(q, 1'b0, len);
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_strings();
    logic [7:0] msg[$];
    // single bytes at both ends, empty forms, short and two-byte lengths
    msg = {8'h00, 8'h7f, 8'h80, 8'h81, 8'hff, 8'hb8, 8'h00,
           8'hb9, 8'h00, 8'h02, 8'haa, 8'h55, 8'h83, 8'h01, 8'h02, 8'h03};
    send_msg(msg, msg.size());
    // cut short by a new message start
    msg = {8'h84, 8'h10};
    send_msg(msg, msg.size());
    msg = {8'h05};
    send_msg(msg, msg.size());
  endtask

  task automatic test_lists();
    logic [7:0] msg[$];
    // empty lists, long form lists, lists closing together
    msg = {8'hc0, 8'hc3, 8'h80, 8'hc0, 8'h01, 8'hf8, 8'h00, 8'hf9, 8'h00, 8'h02,
           8'h81, 8'h33, 8'hc2, 8'hc1, 8'hc0, 8'h05};
    send_msg(msg, msg.size());
  endtask

  task automatic test_errors();
    logic [7:0] msg[$];
    // length too long, then ignored bytes
    msg = {8'hba, 8'h01, 8'h02};
    send_msg(msg, msg.size());
    msg = {8'hfa, 8'h00};
    send_msg(msg, msg.size());
    msg = {8'hff};
    send_msg(msg, msg.size());
    msg = {8'hbf};
    send_msg(msg, msg.size());
    // string, list, and length bytes overrunning the enclosing list
    msg = {8'hc2, 8'h83, 8'h01};
    send_msg(msg, msg.size());
    msg = {8'hc1, 8'hc1, 8'h00};
    send_msg(msg, msg.size());
    msg = {8'hc1, 8'hb9};
    send_msg(msg, msg.size());
    msg = {8'hf8, 8'h02, 8'hb8, 8'h05};
    send_msg(msg, msg.size());
  endtask

  task automatic test_depth_limit();
    logic [7:0] msg[$];
    // eight open lists, a string at full depth, then every list closes at once
    msg = {8'hc8, 8'hc7, 8'hc6, 8'hc5, 8'hc4, 8'hc3, 8'hc2, 8'hc1, 8'h42, 8'h11};
    send_msg(msg, msg.size());
    // a ninth list
    msg = {8'hc8, 8'hc7, 8'hc6, 8'hc5, 8'hc4, 8'hc3, 8'hc2, 8'hc1, 8'hc0};
    send_msg(msg, msg.size());
    // a ninth list with an oversized length field
    msg[8] = 8'hfb;
    send_msg(msg, msg.size());
  endtask

  task automatic test_item_limit();
    logic [7:0] msg[$];
    // full item count, a list is still allowed, the next string is not
    msg.delete();
    repeat (LIM_ITEMS) msg.push_back(8'($urandom_range(0, 127)));
    msg.push_back(8'hc0);
    msg.push_back(8'h80);
    send_msg(msg, msg.size());
    // oversized length wins over the item limit
    msg.delete();
    repeat (LIM_ITEMS) msg.push_back(8'($urandom_range(0, 127)));
    msg.push_back(8'hbb);
    send_msg(msg, msg.size());
    // overrun wins over the item limit
    msg = {8'hf9, 8'h00, 8'h81};
    repeat (LIM_ITEMS) msg.push_back(8'($urandom_range(0, 127)));
    msg.push_back(8'h82);
    send_msg(msg, msg.size());
  endtask

  task automatic test_backpressure();
    logic [7:0] msg[$];
    // hold the receiver off and keep offering bytes so the block stalls its input
    tx_quiet    = 1'b1;
    rx_hold_req = 300;
    repeat (3) begin
      msg.delete();
      gen_item(msg, 2);
      gen_item(msg, 1);
      send_msg(msg, msg.size());
    end
    tx_quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_random();
    logic [7:0]  msg[$];
    logic [7:0]  wrap[$];
    int unsigned r;
    int unsigned start_live;
    start_live = n_live;
    while (n_live - start_live < RAND_ITEMS) begin
      // a stretch with no idling on either side
      tx_quiet = (n_live - start_live >= 80 && n_live - start_live < 140);
      rx_quiet = tx_quiet;
      r = $urandom_range(0, 99);
      msg.delete();
      if (r < 95) begin
        gen_item(msg, $urandom_range(0, 3));
      end
      if (r < 65) begin
        // well-formed, sometimes with a trailing top-level item
        if ($urandom_range(0, 5) == 0) gen_item(msg, 1);
        send_msg(msg, msg.size());
      end else if (r < 80) begin
        // one corrupted byte
        msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
        send_msg(msg, msg.size());
      end else if (r < 90) begin
        // truncated, the next start clears it
        send_msg(msg, $urandom_range(1, msg.size()));
      end else if (r < 95) begin
        // deep nesting around a small item, up to one past the limit
        msg.delete();
        gen_item(msg, 0);
        repeat ($urandom_range(6, 9)) begin
          wrap.delete();
          put_header(wrap, 1'b1, msg.size());
          msg = {wrap, msg};
        end
        send_msg(msg, msg.size());
      end else begin
        // raw noise with occasional message starts
        repeat ($urandom_range(1, 12))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    clear_decoder();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_strings();
    test_lists();
    test_errors();
    test_depth_limit();
    test_item_limit();
    test_backpressure();
    test_random();

    // drain, then allow the output register to settle
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (decoded_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (decoded_q.size() != 0) report_mismatch("results never delivered", decoded_q.size(), 0);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== rlp_stream_decoder_top.f =====
rtl/rlpd_pkg.sv
rtl/rlpd_cell.sv
rtl/rlp_stream_decoder_top.sv
tb/tb.sv
